// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a delayed consequent, disabled during reset
`define ASSERT_DELAY2(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/phr_pkg.sv =====
// ----------------------------------------------------------------------------
// phr_pkg
// Types, codes and constants shared by the press/hold ramp modules.
// ----------------------------------------------------------------------------
package phr_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned STEP_W     = 31;
    localparam int unsigned TIMER_W    = 16;
    localparam int unsigned EL_W       = 10;
    localparam int unsigned K_W        = 20;   // holds 655 * 1023
    localparam int unsigned OP_W       = 3;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // 0.01 in Q0.16, rounded down; 1.0 in Q16.16
    localparam logic [K_W-1:0]     RATE_Q16 = K_W'(655);
    localparam logic [VALUE_W-1:0] Q_ONE    = VALUE_W'(65536);

    // Register reset values
    localparam logic signed [VALUE_W-1:0] RST_NORMAL = 32'sd0;
    localparam logic signed [VALUE_W-1:0] RST_UPPER  = 32'sd6553600;
    localparam logic signed [VALUE_W-1:0] RST_LOWER  = -32'sd6553600;
    localparam logic [TIMER_W-1:0]        RST_DELAY  = '0;
    localparam logic [STEP_W-1:0]         RST_START  = STEP_W'(65536);
    localparam logic [STEP_W-1:0]         RST_MIN    = STEP_W'(6554);
    localparam logic [STEP_W-1:0]         RST_MAX    = STEP_W'(655360);

    typedef enum logic [OP_W-1:0] {
        OP_TICK         = 3'd0,
        OP_PRESS_UP     = 3'd1,
        OP_PRESS_DOWN   = 3'd2,
        OP_RELEASE_UP   = 3'd3,
        OP_RELEASE_DOWN = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL  = 3'd0,
        CFG_UPPER   = 3'd1,
        CFG_LOWER   = 3'd2,
        CFG_DELAY   = 3'd3,
        CFG_START   = 3'd4,
        CFG_MIN     = 3'd5,
        CFG_MAX     = 3'd6,
        CFG_RECOVER = 3'd7
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        REC_SLOW      = 2'd0,
        REC_IMMEDIATE = 2'd1,
        REC_NONE      = 2'd2
    } t_recover;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_PRESS_UP,
        CMD_PRESS_DOWN,
        CMD_RELEASE_UP,
        CMD_RELEASE_DOWN,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [EL_W-1:0]    elapsed;
        logic [K_W-1:0]     k;        // 655 * elapsed
    } t_cmd;

    typedef struct packed {
        logic signed [VALUE_W-1:0] normal_value;
        logic signed [VALUE_W-1:0] upper_limit;
        logic signed [VALUE_W-1:0] lower_limit;
        logic [TIMER_W-1:0]        hold_delay;
        logic [STEP_W-1:0]         start_step;
        logic [STEP_W-1:0]         min_step;
        logic [STEP_W-1:0]         max_step;
        logic [MODE_W-1:0]         recover_mode;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/core/phr_front.sv =====
// ----------------------------------------------------------------------------
// phr_front
// Input side: takes events, decodes the op and precomputes the rate product.
// ----------------------------------------------------------------------------
module phr_front (
    input  logic                          i_in_valid,
    input  logic [phr_pkg::OP_W-1:0]      i_op,
    input  logic [phr_pkg::EL_W-1:0]      i_elapsed,
    input  phr_pkg::t_q_status            i_q_status,
    output logic                          o_in_ready,
    output logic                          o_push,
    output phr_pkg::t_cmd                 o_cmd
);

    phr_pkg::t_cmd_kind w_kind;

    always_comb begin
        unique case (phr_pkg::t_op'(i_op))
            phr_pkg::OP_TICK:         w_kind = phr_pkg::CMD_TICK;
            phr_pkg::OP_PRESS_UP:     w_kind = phr_pkg::CMD_PRESS_UP;
            phr_pkg::OP_PRESS_DOWN:   w_kind = phr_pkg::CMD_PRESS_DOWN;
            phr_pkg::OP_RELEASE_UP:   w_kind = phr_pkg::CMD_RELEASE_UP;
            phr_pkg::OP_RELEASE_DOWN: w_kind = phr_pkg::CMD_RELEASE_DOWN;
            default:                  w_kind = phr_pkg::CMD_NOP;
        endcase
    end

    assign o_in_ready    = !i_q_status.full;
    assign o_push        = i_in_valid && o_in_ready;
    assign o_cmd.kind    = w_kind;
    assign o_cmd.elapsed = i_elapsed;
    // constant multiply; narrow enough to fold into adders
    assign o_cmd.k       = phr_pkg::RATE_Q16 * phr_pkg::K_W'(i_elapsed);

endmodule

// ===== rtl/core/phr_queue.sv =====
// ----------------------------------------------------------------------------
// phr_queue
// Short command queue between the decode side and the execute side.
// ----------------------------------------------------------------------------
module phr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  phr_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output phr_pkg::t_cmd      o_cmd,
    output phr_pkg::t_q_status o_status
);

    localparam int unsigned AW = phr_pkg::QUEUE_AW;

    phr_pkg::t_cmd  r_mem [phr_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [AW:0]    r_count,  n_count;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] ptr);
        if (ptr == AW'(phr_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return ptr + AW'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? f_wrap(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? f_wrap(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (AW+1)'(phr_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ===== rtl/core/phr_back.sv =====
// ----------------------------------------------------------------------------
// phr_back
// Execute side: holds the ramp state, applies one command per cycle unless a
// stalled result holds it, and registers the result.
// ----------------------------------------------------------------------------
module phr_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  phr_pkg::t_cfg                       i_cfg,
    input  logic                                i_cmd_valid,
    input  phr_pkg::t_cmd                       i_cmd,
    input  logic                                i_out_ready,
    output logic                                o_pop,
    output logic                                o_out_valid,
    output logic signed [phr_pkg::VALUE_W-1:0]  o_value,
    output logic                                o_recovered
);

    localparam int unsigned VW = phr_pkg::VALUE_W;
    localparam int unsigned SW = phr_pkg::STEP_W;
    localparam int unsigned TW = phr_pkg::TIMER_W;
    localparam int unsigned KW = phr_pkg::K_W;
    localparam int unsigned PW = VW + KW;          // product width
    localparam int unsigned MW = PW - 16;          // product >> 16
    localparam int unsigned RW = MW + 2;           // recovery sum width

    // architectural state
    logic signed [VW-1:0] r_value, n_value;
    logic [SW-1:0]        r_step,  n_step;
    logic [TW-1:0]        r_timer, n_timer;
    logic                 r_up,    n_up;
    logic                 r_down,  n_down;
    logic                 r_rec,   n_rec;

    // result register
    logic                 r_out_valid;
    logic signed [VW-1:0] r_out_value;
    logic                 r_out_rec;

    logic signed [VW-1:0] w_hi, w_lo;
    logic [TW:0]          w_timer_sum;
    logic                 w_timer_exp;
    logic [SW:0]          w_grow;
    logic [SW-1:0]        w_grow_step;
    logic [SW:0]          w_decay;
    logic [SW-1:0]        w_decay_step;
    logic [SW-1:0]        w_move_step;
    logic signed [VW+1:0] w_up_sum, w_dn_sum;
    logic [VW-1:0]        w_up_val, w_dn_val;
    logic signed [VW:0]   w_d, w_neg_d;
    logic [VW-1:0]        w_mag;
    logic [PW-1:0]        w_prod;
    logic [MW-1:0]        w_m;
    logic signed [RW-1:0] w_rec_sum;
    logic signed [VW-1:0] w_rec_val;
    logic                 w_pop;

    assign w_pop = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_pop = w_pop;

    // wrong-order limits: larger one is the upper bound
    assign w_hi = (i_cfg.upper_limit > i_cfg.lower_limit) ? i_cfg.upper_limit
                                                          : i_cfg.lower_limit;
    assign w_lo = (i_cfg.upper_limit > i_cfg.lower_limit) ? i_cfg.lower_limit
                                                          : i_cfg.upper_limit;

    // hold timer
    assign w_timer_sum = {1'b0, r_timer} + (TW+1)'(i_cmd.elapsed);
    assign w_timer_exp = !(r_timer < i_cfg.hold_delay);

    // step grow toward max_step, kept when already above
    assign w_grow = {1'b0, r_step} + (SW+1)'(i_cmd.k);
    always_comb begin
        w_grow_step = r_step;
        if (r_step < i_cfg.max_step) begin
            w_grow_step = (w_grow > {1'b0, i_cfg.max_step}) ? i_cfg.max_step : w_grow[SW-1:0];
        end
    end

    // step decay toward min_step
    assign w_decay = {1'b0, r_step} - (SW+1)'(i_cmd.k);
    always_comb begin
        w_decay_step = r_step;
        if (r_step > i_cfg.min_step) begin
            w_decay_step = (w_decay[SW] || (w_decay[SW-1:0] < i_cfg.min_step))
                           ? i_cfg.min_step : w_decay[SW-1:0];
        end
    end

    // one move adder pair shared by press and held tick
    assign w_move_step = (i_cmd.kind == phr_pkg::CMD_TICK) ? w_grow_step : i_cfg.start_step;
    assign w_up_sum = $signed({{2{r_value[VW-1]}}, r_value}) + $signed({2'b00, w_move_step});
    assign w_dn_sum = $signed({{2{r_value[VW-1]}}, r_value}) - $signed({2'b00, w_move_step});
    assign w_up_val = (w_up_sum > $signed({{2{w_hi[VW-1]}}, w_hi})) ? w_hi : w_up_sum[VW-1:0];
    assign w_dn_val = (w_dn_sum < $signed({{2{w_lo[VW-1]}}, w_lo})) ? w_lo : w_dn_sum[VW-1:0];

    // slow recovery: move by |d| * k >> 16 toward normal, truncated toward zero
    assign w_d     = $signed({i_cfg.normal_value[VW-1], i_cfg.normal_value})
                   - $signed({r_value[VW-1], r_value});
    assign w_neg_d = -w_d;
    assign w_mag   = w_d[VW] ? w_neg_d[VW-1:0] : w_d[VW-1:0];
    assign w_prod  = PW'(w_mag) * PW'(i_cmd.k);
    assign w_m     = w_prod[PW-1:16];
    assign w_rec_sum = w_d[VW]
        ? $signed({{(RW-VW){r_value[VW-1]}}, r_value}) - $signed({2'b00, w_m})
        : $signed({{(RW-VW){r_value[VW-1]}}, r_value}) + $signed({2'b00, w_m});
    always_comb begin
        if (w_rec_sum > $signed(RW'({1'b0, {(VW-1){1'b1}}}))) begin
            w_rec_val = {1'b0, {(VW-1){1'b1}}};
        end else if (w_rec_sum < $signed({{(RW-VW+1){1'b1}}, {(VW-1){1'b0}}})) begin
            w_rec_val = {1'b1, {(VW-1){1'b0}}};
        end else begin
            w_rec_val = w_rec_sum[VW-1:0];
        end
    end

    always_comb begin
        n_value = r_value;
        n_step  = r_step;
        n_timer = r_timer;
        n_up    = r_up;
        n_down  = r_down;
        n_rec   = r_rec;
        if (w_pop) begin
            unique case (i_cmd.kind)
                phr_pkg::CMD_TICK: begin
                    if (r_up && r_down) begin
                        // both held: freeze
                    end else if (r_up || r_down) begin
                        if (!w_timer_exp) begin
                            n_timer = (w_timer_sum > {1'b0, i_cfg.hold_delay})
                                      ? i_cfg.hold_delay : w_timer_sum[TW-1:0];
                        end else begin
                            n_step = w_grow_step;
                            if (r_up) begin
                                if (r_value < w_hi) begin
                                    n_value = w_up_val;
                                    n_rec   = 1'b0;
                                end
                            end else if (r_value > w_lo) begin
                                n_value = w_dn_val;
                                n_rec   = 1'b0;
                            end
                        end
                    end else begin
                        n_step = w_decay_step;
                        if (!r_rec) begin
                            case (phr_pkg::t_recover'(i_cfg.recover_mode))
                                phr_pkg::REC_SLOW: begin
                                    if (w_mag < phr_pkg::Q_ONE) begin
                                        n_value = i_cfg.normal_value;
                                        n_rec   = 1'b1;
                                    end else begin
                                        n_value = w_rec_val;
                                    end
                                end
                                phr_pkg::REC_IMMEDIATE: begin
                                    n_value = i_cfg.normal_value;
                                    n_rec   = 1'b1;
                                end
                                default: begin
                                    // no recovery
                                end
                            endcase
                        end
                    end
                end
                phr_pkg::CMD_PRESS_UP: begin
                    if (!r_up && !r_down) begin
                        n_timer = '0;
                        if (r_value < w_hi) begin
                            n_value = w_up_val;
                            n_rec   = 1'b0;
                        end
                    end
                    n_up = 1'b1;
                end
                phr_pkg::CMD_PRESS_DOWN: begin
                    if (!r_up && !r_down) begin
                        n_timer = '0;
                        if (r_value > w_lo) begin
                            n_value = w_dn_val;
                            n_rec   = 1'b0;
                        end
                    end
                    n_down = 1'b1;
                end
                phr_pkg::CMD_RELEASE_UP:   n_up   = 1'b0;
                phr_pkg::CMD_RELEASE_DOWN: n_down = 1'b0;
                default: begin
                    // unused op: report state
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value     <= phr_pkg::RST_NORMAL;
            r_step      <= phr_pkg::RST_MIN;
            r_timer     <= '0;
            r_up        <= 1'b0;
            r_down      <= 1'b0;
            r_rec       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_value <= n_value;
            r_step  <= n_step;
            r_timer <= n_timer;
            r_up    <= n_up;
            r_down  <= n_down;
            r_rec   <= n_rec;
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_out_value <= n_value;
            r_out_rec   <= n_rec;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_recovered = r_out_rec;

endmodule

// ===== rtl/core/press_hold_ramp_bidirectional.sv =====
// ----------------------------------------------------------------------------
// press_hold_ramp_bidirectional
// Two-button Q16.16 value ramp with hold delay, step growth and recovery.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one event per transfer:
//   i_op selects tick, press up/down or release up/down; i_elapsed gives the
//   time units of a tick. Every event yields exactly one result transfer on
//   the output channel (o_out_valid / i_out_ready): o_value and o_recovered.
//   o_out_valid rises once the event has passed the registered command
//   queue and the execute stage, which takes it from the queue head and
//   registers its result; the result can then transfer out. The execute
//   state update feeds back to itself each cycle. The block accepts one
//   event per cycle while the receiver does not stall the result.
//   A stalled receiver holds the result register; the 2-entry queue keeps
//   absorbing events, and o_in_ready drops only when it is full.
//   Configuration (i_cfg_wr_en, i_cfg_index, i_cfg_data) writes a register
//   at once; write it only while no event is in flight.
//   Synchronous active-low reset restores register defaults, puts the value
//   at rest (0, recovered) and empties the queue and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module press_hold_ramp_bidirectional (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // event channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [phr_pkg::OP_W-1:0]               i_op,
    input  logic [phr_pkg::EL_W-1:0]               i_elapsed,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [phr_pkg::VALUE_W-1:0]     o_value,
    output logic                                   o_recovered,
    // configuration write port
    input  logic                                   i_cfg_wr_en,
    input  logic [phr_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [phr_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    phr_pkg::t_cfg      r_cfg;
    phr_pkg::t_q_status w_q_status;
    phr_pkg::t_cmd      w_push_cmd;
    phr_pkg::t_cmd      w_head_cmd;
    logic               w_push;
    logic               w_pop;

    // Configuration registers: truncate the write data to each field.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_value <= phr_pkg::RST_NORMAL;
            r_cfg.upper_limit  <= phr_pkg::RST_UPPER;
            r_cfg.lower_limit  <= phr_pkg::RST_LOWER;
            r_cfg.hold_delay   <= phr_pkg::RST_DELAY;
            r_cfg.start_step   <= phr_pkg::RST_START;
            r_cfg.min_step     <= phr_pkg::RST_MIN;
            r_cfg.max_step     <= phr_pkg::RST_MAX;
            r_cfg.recover_mode <= phr_pkg::REC_SLOW;
        end else if (i_cfg_wr_en) begin
            unique case (phr_pkg::t_cfg_idx'(i_cfg_index))
                phr_pkg::CFG_NORMAL:  r_cfg.normal_value <= $signed(i_cfg_data);
                phr_pkg::CFG_UPPER:   r_cfg.upper_limit  <= $signed(i_cfg_data);
                phr_pkg::CFG_LOWER:   r_cfg.lower_limit  <= $signed(i_cfg_data);
                phr_pkg::CFG_DELAY:   r_cfg.hold_delay   <= i_cfg_data[phr_pkg::TIMER_W-1:0];
                phr_pkg::CFG_START:   r_cfg.start_step   <= i_cfg_data[phr_pkg::STEP_W-1:0];
                phr_pkg::CFG_MIN:     r_cfg.min_step     <= i_cfg_data[phr_pkg::STEP_W-1:0];
                phr_pkg::CFG_MAX:     r_cfg.max_step     <= i_cfg_data[phr_pkg::STEP_W-1:0];
                phr_pkg::CFG_RECOVER: r_cfg.recover_mode <= i_cfg_data[phr_pkg::MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Decode side: classify the event and precompute 655 * elapsed.
    phr_front u_front (
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_elapsed  (i_elapsed),
        .i_q_status (w_q_status),
        .o_in_ready (o_in_ready),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    // Decouple the two sides so each can stall on its own.
    phr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    // Execute side: ramp state and result register.
    phr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (!w_q_status.empty),
        .i_cmd       (w_head_cmd),
        .i_out_ready (i_out_ready),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_value     (o_value),
        .o_recovered (o_recovered)
    );

    // Never consume a command that is not there.
    `ASSERT_IMPL(a_pop_has_cmd, i_clk, i_rst_n, w_pop, !w_q_status.empty, "pop from empty queue")
    // A held result must not be overwritten by a new command.
    `ASSERT_IMPL(a_no_pop_on_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready, !w_pop, "pop while result stalled")
    // An event into an idle block is offered once it has passed the queue and the result register.
    `ASSERT_DELAY2(a_idle_latency, i_clk, i_rst_n, i_in_valid && o_in_ready && w_q_status.empty && !o_out_valid, o_out_valid, "idle latency not two cycles")

endmodule

// ===== sim/press_hold_ramp_bidirectional_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// press_hold_ramp_bidirectional_tb
// Self-checking bench for the two-button Q16.16 value ramp. A queue of button
// and tick events feeds a valid/ready driver. Each accepted event runs
// through a local model of the ramp: hold timer, step growth and decay,
// clamping, freeze and the three recovery modes. The model result is
// queued, and the monitor checks each result transfer against it. Settings
// change only between phases, once the block has drained.
// ----------------------------------------------------------------------------
module press_hold_ramp_bidirectional_tb;

    localparam int    CLK_HALF      = 5;
    localparam int    DRAIN_CYCLES  = 4;      // pipeline is two deep
    localparam int    HOLD_CYCLES   = 150;    // long receiver hold-off
    localparam int    CYCLE_LIMIT   = 100000;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint S32_MIN      = -64'sd2147483648;
    localparam logic [31:0] STEP_TOP = 32'h7fff_ffff;   // widest 31-bit step
    // op codes with no action
    localparam logic [phr_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [phr_pkg::OP_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [phr_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;
    localparam logic [phr_pkg::MODE_W-1:0] REC_SPARE    = 2'd3;  // behaves as no recovery

    typedef struct {
        logic [phr_pkg::OP_W-1:0] op;
        logic [phr_pkg::EL_W-1:0] elapsed;
    } t_ramp_event;

    typedef struct {
        logic signed [phr_pkg::VALUE_W-1:0] value;
        logic                               recovered;
    } t_ramp_result;

    // ------------------------------------------------------------------
    // DUT connections, inputs known from time zero
    // ------------------------------------------------------------------
    logic                                i_clk       = 1'b0;
    logic                                i_rst_n     = 1'b0;
    logic                                i_in_valid  = 1'b0;
    logic                                o_in_ready;
    logic [phr_pkg::OP_W-1:0]            i_op        = '0;
    logic [phr_pkg::EL_W-1:0]            i_elapsed   = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic signed [phr_pkg::VALUE_W-1:0]  o_value;
    logic                                o_recovered;
    logic                                i_cfg_wr_en = 1'b0;
    logic [phr_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [phr_pkg::CFG_DATA_W-1:0]      i_cfg_data  = '0;

    press_hold_ramp_bidirectional dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_elapsed   (i_elapsed),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_recovered (o_recovered),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Ramp model: settings and state, starting from the reset values
    // ------------------------------------------------------------------
    longint     set_normal = phr_pkg::RST_NORMAL;
    longint     set_upper  = phr_pkg::RST_UPPER;
    longint     set_lower  = phr_pkg::RST_LOWER;
    longint     set_delay  = phr_pkg::RST_DELAY;
    longint     set_start  = phr_pkg::RST_START;
    longint     set_floor  = phr_pkg::RST_MIN;
    longint     set_ceil   = phr_pkg::RST_MAX;
    logic [1:0] set_mode   = phr_pkg::REC_SLOW;

    longint ramp_value = phr_pkg::RST_NORMAL;
    longint ramp_step  = phr_pkg::RST_MIN;
    longint hold_time  = 0;
    bit     up_down    = 1'b0;
    bit     down_down  = 1'b0;
    bit     at_rest    = 1'b1;

    t_ramp_event  event_q[$];          // events waiting for the driver
    t_ramp_result ramp_result_q[$];    // model results waiting for the DUT

    int events_queued   = 0;
    int events_sent     = 0;
    int results_checked = 0;
    int error_count     = 0;
    int phases_run      = 1;
    int holds_done      = 0;
    int rx_hold_left    = 0;
    int next_hold_at    = 300;
    int cycle_count     = 0;

    // Apply one accepted event to the model and queue its result
    task automatic predict_event(input logic [phr_pkg::OP_W-1:0] op,
                                 input logic [phr_pkg::EL_W-1:0] el);
        longint       hi, lo, k, d, mag, m, t;
        t_ramp_result res;
        // limits written in the wrong order swap roles
        hi = (set_upper > set_lower) ? set_upper : set_lower;
        lo = (set_upper > set_lower) ? set_lower : set_upper;
        k  = longint'(phr_pkg::RATE_Q16) * longint'(el);
        case (op)
            phr_pkg::OP_TICK: begin
                if (up_down && down_down) begin
                    // both held: freeze
                end else if (up_down || down_down) begin
                    if (hold_time < set_delay) begin
                        t = hold_time + longint'(el);
                        hold_time = (t > set_delay) ? set_delay : t;
                    end else begin
                        // a step already above the ceiling is kept as is
                        if (ramp_step < set_ceil) begin
                            ramp_step += k;
                            if (ramp_step > set_ceil) ramp_step = set_ceil;
                        end
                        if (up_down) begin
                            if (ramp_value < hi) begin
                                t = ramp_value + ramp_step;
                                ramp_value = (t > hi) ? hi : t;
                                at_rest = 1'b0;
                            end
                        end else if (ramp_value > lo) begin
                            t = ramp_value - ramp_step;
                            ramp_value = (t < lo) ? lo : t;
                            at_rest = 1'b0;
                        end
                    end
                end else begin
                    // released: decay the step, then recover
                    if (ramp_step > set_floor) begin
                        ramp_step -= k;
                        if (ramp_step < set_floor) ramp_step = set_floor;
                    end
                    if (!at_rest) begin
                        if (set_mode == phr_pkg::REC_SLOW) begin
                            d   = set_normal - ramp_value;
                            mag = (d < 0) ? -d : d;
                            if (mag < longint'(phr_pkg::Q_ONE)) begin
                                ramp_value = set_normal;
                                at_rest    = 1'b1;
                            end else begin
                                m = (mag * k) >>> 16;
                                t = (d < 0) ? ramp_value - m : ramp_value + m;
                                ramp_value = (t > S32_MAX) ? S32_MAX :
                                             (t < S32_MIN) ? S32_MIN : t;
                            end
                        end else if (set_mode == phr_pkg::REC_IMMEDIATE) begin
                            ramp_value = set_normal;
                            at_rest    = 1'b1;
                        end
                    end
                end
            end
            phr_pkg::OP_PRESS_UP, phr_pkg::OP_PRESS_DOWN: begin
                // only a first press moves the value
                if (!up_down && !down_down) begin
                    hold_time = 0;
                    if (op == phr_pkg::OP_PRESS_UP) begin
                        if (ramp_value < hi) begin
                            t = ramp_value + set_start;
                            ramp_value = (t > hi) ? hi : t;
                            at_rest = 1'b0;
                        end
                    end else if (ramp_value > lo) begin
                        t = ramp_value - set_start;
                        ramp_value = (t < lo) ? lo : t;
                        at_rest = 1'b0;
                    end
                end
                if (op == phr_pkg::OP_PRESS_UP) up_down = 1'b1;
                else                            down_down = 1'b1;
            end
            phr_pkg::OP_RELEASE_UP:   up_down   = 1'b0;
            phr_pkg::OP_RELEASE_DOWN: down_down = 1'b0;
            default: ;
        endcase
        res.value     = ramp_value[phr_pkg::VALUE_W-1:0];
        res.recovered = at_rest;
        ramp_result_q.push_back(res);
    endtask

    // Print one mismatch line and count it
    task automatic report_error(input string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Idle with a chance of 6 in 100, except in a steady stretch mid-run
    function automatic bit take_break();
        return (events_sent < 900 || events_sent >= 1150) && ($urandom_range(99) < 6);
    endfunction

    // Elapsed time: mostly short ticks, often medium, sometimes full range
    function automatic logic [phr_pkg::EL_W-1:0] random_elapsed();
        case ($urandom_range(3))
            0, 1:    return phr_pkg::EL_W'($urandom_range(15));
            2:       return phr_pkg::EL_W'($urandom_range(100));
            default: return phr_pkg::EL_W'($urandom_range(1023));
        endcase
    endfunction

    task automatic add_event(input logic [phr_pkg::OP_W-1:0] op,
                             input logic [phr_pkg::EL_W-1:0] el);
        t_ramp_event ev;
        ev.op      = op;
        ev.elapsed = el;
        event_q.push_back(ev);
        events_queued++;
    endtask

    // Queue about n events: mostly press/hold/release runs, some noise
    task automatic fill_random(input int n);
        int target;
        bit up;
        target = events_queued + n;
        while (events_queued < target) begin
            if ($urandom_range(9) < 8) begin
                up = 1'($urandom_range(1));
                add_event(up ? phr_pkg::OP_PRESS_UP : phr_pkg::OP_PRESS_DOWN,
                          random_elapsed());
                repeat ($urandom_range(12, 1)) add_event(phr_pkg::OP_TICK, random_elapsed());
                if ($urandom_range(4) == 0) begin
                    // other button too: freeze, then let go in either order
                    add_event(up ? phr_pkg::OP_PRESS_DOWN : phr_pkg::OP_PRESS_UP,
                              random_elapsed());
                    repeat ($urandom_range(3, 1)) add_event(phr_pkg::OP_TICK, random_elapsed());
                    add_event(up ? phr_pkg::OP_RELEASE_UP : phr_pkg::OP_RELEASE_DOWN,
                              random_elapsed());
                    repeat ($urandom_range(4, 1)) add_event(phr_pkg::OP_TICK, random_elapsed());
                    add_event(up ? phr_pkg::OP_RELEASE_DOWN : phr_pkg::OP_RELEASE_UP,
                              random_elapsed());
                end else begin
                    add_event(up ? phr_pkg::OP_RELEASE_UP : phr_pkg::OP_RELEASE_DOWN,
                              random_elapsed());
                end
                repeat ($urandom_range(10, 1)) add_event(phr_pkg::OP_TICK, random_elapsed());
            end else if ($urandom_range(9) == 0) begin
                add_event(phr_pkg::OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
                          random_elapsed());
            end else begin
                add_event(phr_pkg::OP_W'($urandom_range(phr_pkg::OP_RELEASE_DOWN,
                                                        phr_pkg::OP_TICK)),
                          random_elapsed());
            end
        end
    endtask

    // Wait until every event is through and every result has arrived
    task automatic drain();
        while (event_q.size() != 0 || i_in_valid || ramp_result_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input phr_pkg::t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            phr_pkg::CFG_NORMAL:  set_normal = $signed(data);
            phr_pkg::CFG_UPPER:   set_upper  = $signed(data);
            phr_pkg::CFG_LOWER:   set_lower  = $signed(data);
            phr_pkg::CFG_DELAY:   set_delay  = data[phr_pkg::TIMER_W-1:0];
            phr_pkg::CFG_START:   set_start  = data[phr_pkg::STEP_W-1:0];
            phr_pkg::CFG_MIN:     set_floor  = data[phr_pkg::STEP_W-1:0];
            phr_pkg::CFG_MAX:     set_ceil   = data[phr_pkg::STEP_W-1:0];
            phr_pkg::CFG_RECOVER: set_mode   = data[phr_pkg::MODE_W-1:0];
            default: ;
        endcase
    endtask

    // Drain, then rewrite every register; ramp state carries over
    task automatic load_settings(input logic [31:0] normal, upper, lower, delay,
                                 input logic [31:0] start, floor_step, ceil_step, mode);
        drain();
        write_reg(phr_pkg::CFG_NORMAL,  normal);
        write_reg(phr_pkg::CFG_UPPER,   upper);
        write_reg(phr_pkg::CFG_LOWER,   lower);
        write_reg(phr_pkg::CFG_DELAY,   delay);
        write_reg(phr_pkg::CFG_START,   start);
        write_reg(phr_pkg::CFG_MIN,     floor_step);
        write_reg(phr_pkg::CFG_MAX,     ceil_step);
        write_reg(phr_pkg::CFG_RECOVER, mode);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        phases_run++;
    endtask

    // ------------------------------------------------------------------
    // Event driver: hold valid and payload until the transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_events
        t_ramp_event nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_event(i_op, i_elapsed);
                events_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (event_q.size() != 0 && !take_break()) begin
                    nxt = event_q.pop_front();
                    i_op       <= nxt.op;
                    i_elapsed  <= nxt.elapsed;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off while plenty of events are still queued,
    // so the input side fills up and backs off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_left <= 0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (events_sent >= next_hold_at && event_q.size() > 16) begin
            rx_hold_left <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 700;
            holds_done   <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each transfer with the oldest model result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_ramp_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (ramp_result_q.size() == 0) begin
                    report_error($sformatf("result with nothing pending: value %0d rec %0b",
                                           o_value, o_recovered));
                end else begin
                    want = ramp_result_q.pop_front();
                    if (o_value !== want.value)
                        report_error($sformatf("result %0d: value %0d, model %0d",
                                               results_checked, o_value, want.value));
                    if (o_recovered !== want.recovered)
                        report_error($sformatf("result %0d: recovered %b, model %b",
                                               results_checked, o_recovered, want.recovered));
                    results_checked++;
                end
            end
            i_out_ready <= (rx_hold_left == 0) && !take_break();
        end
    end

    // Bound the run in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, ramp_result_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Phases: directed events on reset settings, then fixed corner settings,
    // then random settings, each followed by random event streams
    // ------------------------------------------------------------------
    initial begin : run_phases
        logic [31:0] nv, ul, ll, dl, ss, fs, cs;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle tick at rest, first press, full-range ticks,
        // freeze with both held, ramp down, slow recovery with zero and
        // overshooting ticks, stray release, unused ops
        add_event(phr_pkg::OP_TICK,         10'd0);
        add_event(phr_pkg::OP_PRESS_UP,     10'd0);
        add_event(phr_pkg::OP_TICK,         10'd1023);
        add_event(phr_pkg::OP_TICK,         10'd1);
        add_event(phr_pkg::OP_PRESS_DOWN,   10'd0);
        add_event(phr_pkg::OP_TICK,         10'd500);
        add_event(phr_pkg::OP_RELEASE_UP,   10'd0);
        add_event(phr_pkg::OP_TICK,         10'd3);
        add_event(phr_pkg::OP_RELEASE_DOWN, 10'd0);
        add_event(phr_pkg::OP_TICK,         10'd0);
        add_event(phr_pkg::OP_TICK,         10'd100);
        add_event(phr_pkg::OP_TICK,         10'd1023);
        add_event(phr_pkg::OP_RELEASE_UP,   10'd1023);
        add_event(OP_SPARE_FIRST,           10'd682);
        add_event(OP_SPARE_MID,             10'd341);
        add_event(OP_SPARE_LAST,            10'd1023);
        add_event(phr_pkg::OP_PRESS_DOWN,   10'd0);
        repeat (4) add_event(phr_pkg::OP_TICK, 10'd1023);
        add_event(phr_pkg::OP_PRESS_UP,     10'd0);
        add_event(phr_pkg::OP_RELEASE_DOWN, 10'd0);
        add_event(phr_pkg::OP_TICK,         10'd682);
        add_event(phr_pkg::OP_TICK,         10'd341);
        add_event(phr_pkg::OP_RELEASE_UP,   10'd0);
        add_event(phr_pkg::OP_TICK,         10'd1023);
        fill_random(150);

        // Limits swapped, short hold delay, unbounded ceiling, instant recovery
        load_settings(32'd0, -32'sd6553600, 32'sd6553600, 32'd10,
                      32'd100000, 32'd0, STEP_TOP, 32'(phr_pkg::REC_IMMEDIATE));
        fill_random(160);

        // Full-range limits, longest delay, largest start, ceiling below floor
        load_settings(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff,
                      STEP_TOP, STEP_TOP, 32'd0, 32'(phr_pkg::REC_SLOW));
        // push far below a top rest value: recovery overshoots and saturates
        add_event(phr_pkg::OP_RELEASE_UP,   10'd0);
        add_event(phr_pkg::OP_RELEASE_DOWN, 10'd0);
        add_event(phr_pkg::OP_PRESS_DOWN,   10'd0);
        add_event(phr_pkg::OP_RELEASE_DOWN, 10'd0);
        add_event(phr_pkg::OP_TICK,         10'd1023);
        add_event(phr_pkg::OP_TICK,         10'd1023);
        fill_random(140);
        // leave up held with the timer part way, then drop the delay to zero
        add_event(phr_pkg::OP_RELEASE_DOWN, 10'd0);
        add_event(phr_pkg::OP_RELEASE_UP,   10'd0);
        add_event(phr_pkg::OP_PRESS_UP,     10'd0);
        repeat (3) add_event(phr_pkg::OP_TICK, 10'd1023);

        load_settings(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd0,
                      32'd0, 32'd0, STEP_TOP, 32'(phr_pkg::REC_NONE));
        fill_random(160);

        // spare recovery code, ceiling lowered under a grown step
        load_settings(32'd131072, 32'd3276800, -32'sd3276800, 32'd5,
                      32'd65536, 32'd6554, 32'd20000, 32'(REC_SPARE));
        fill_random(160);

        for (int p = 0; p < 5; p++) begin
            nv = ($urandom_range(3) == 0) ? $urandom
                                          : 32'($urandom_range(13107200)) - 32'd6553600;
            ul = ($urandom_range(4) == 0) ? $urandom : 32'($urandom_range(6553600, 65536));
            ll = ($urandom_range(4) == 0) ? $urandom
                                          : -32'sd1 * 32'($urandom_range(6553600, 65536));
            if ($urandom_range(5) == 0) begin
                dl = ul;
                ul = ll;
                ll = dl;
            end
            case ($urandom_range(9))
                0:       dl = $urandom_range(32'hffff);
                1, 2:    dl = $urandom_range(1000);
                default: dl = $urandom_range(40);
            endcase
            ss = ($urandom_range(5) == 0) ? ($urandom & STEP_TOP) : $urandom_range(200000);
            fs = ($urandom_range(5) == 0) ? ($urandom & STEP_TOP) : $urandom_range(20000);
            cs = ($urandom_range(5) == 0) ? ($urandom & STEP_TOP) : $urandom_range(1500000);
            load_settings(nv, ul, ll, dl, ss, fs, cs, $urandom_range(3));
            fill_random(160);
        end

        drain();
        $display("Ran %0d events over %0d settings phases; %0d results checked.",
                 events_sent, phases_run, results_checked);
        $display("Receiver hold-offs: %0d; mismatches: %0d.", holds_done, error_count);
        if (error_count == 0 && ramp_result_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
